// File: rtl/core/packed_nibble_framebuffer_assert.svh
// Assertion macros used by the frame buffer checker.
`ifndef PACKED_NIBBLE_FRAMEBUFFER_ASSERT_SVH
`define PACKED_NIBBLE_FRAMEBUFFER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PNF_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("frame buffer check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PNF_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("frame buffer check failed");

`endif

// File: rtl/core/pnf_pkg.sv
// Types, constants and state encoding of the packed nibble frame buffer.
package pnf_pkg;

    localparam int WIDTH        = 128;
    localparam int HEIGHT       = 64;
    localparam int ROW_SHIFT    = 6;
    localparam int GLYPH_HEIGHT = 8;
    localparam int STORE_BYTES  = 4096;

    localparam int OP_W   = 3;
    localparam int X_W    = 7;
    localparam int Y_W    = 6;
    localparam int LINE_W = 3;
    localparam int LVL_W  = 4;
    localparam int BIDX_W = 12;
    localparam int BYTE_W = 8;

    localparam int ADDR_W = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;

    // Band rows reach up to eight glyph heights.
    localparam int BAND_ROW_W = $clog2(8 * GLYPH_HEIGHT);
    localparam int GH_W       = (GLYPH_HEIGHT > 1) ? $clog2(GLYPH_HEIGHT) : 1;
    localparam int BCOL_W     = ((WIDTH + 1) / 2 > 1) ? $clog2((WIDTH + 1) / 2) : 1;

    localparam int ROW_MAX_W   = (Y_W > BAND_ROW_W) ? Y_W : BAND_ROW_W;
    localparam int SHIFTED_W   = ROW_MAX_W + ROW_SHIFT;
    localparam int ADDR_CALC_W = ((SHIFTED_W > X_W) ? SHIFTED_W : X_W) + 1;

    localparam logic [GH_W-1:0]   GH_LAST   = GH_W'(GLYPH_HEIGHT - 1);
    localparam logic [BCOL_W-1:0] BCOL_LAST = BCOL_W'((WIDTH - 1) / 2);
    localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(STORE_BYTES - 1);

    localparam logic [OP_W-1:0] OP_WRITE_PIXEL = 3'd0;
    localparam logic [OP_W-1:0] OP_READ_PIXEL  = 3'd1;
    localparam logic [OP_W-1:0] OP_BLANK_BAND  = 3'd2;
    localparam logic [OP_W-1:0] OP_HILITE_BAND = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR       = 3'd4;
    localparam logic [OP_W-1:0] OP_REFRESH     = 3'd5;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [X_W-1:0]    x_pos;
        logic [Y_W-1:0]    y_pos;
        logic [LINE_W-1:0] line_index;
        logic [LVL_W-1:0]  level;
        logic [BIDX_W-1:0] byte_index;
    } pnf_in_t;

    typedef struct packed {
        logic [LVL_W-1:0]  pixel_value;
        logic [BYTE_W-1:0] raw_byte;
    } pnf_out_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_FETCH,
        ST_PIX_WR,
        ST_BAND_RD,
        ST_BAND_WR,
        ST_CLEAR,
        ST_RESP
    } pnf_state_t;

    typedef struct packed {
        logic load;
        logic fetch;
        logic pix_write;
        logic band_read;
        logic band_write;
        logic clr_write;
        logic out_load;
    } pnf_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            band_skip;
        logic            band_last;
        logic            clr_last;
        logic            out_free;
    } pnf_status_t;

endpackage

// File: rtl/core/pnf_ctrl.sv
// Controller state machine of the packed nibble frame buffer.
module pnf_ctrl
    import pnf_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    input  logic [OP_W-1:0] op_in,
    output logic            s_ready,
    output pnf_cmd_t        cmd,
    input  pnf_status_t     status
);

    pnf_state_t state_reg;
    pnf_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT: begin
                if (status.clr_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_valid) begin
                    unique case (op_in)
                        OP_WRITE_PIXEL, OP_READ_PIXEL, OP_REFRESH: state_next = ST_FETCH;
                        OP_BLANK_BAND, OP_HILITE_BAND:             state_next = ST_BAND_RD;
                        OP_CLEAR:                                  state_next = ST_CLEAR;
                        default:                                   state_next = ST_RESP;
                    endcase
                end
            end
            ST_FETCH: begin
                state_next = (status.op == OP_WRITE_PIXEL) ? ST_PIX_WR : ST_RESP;
            end
            ST_PIX_WR: begin
                state_next = ST_RESP;
            end
            ST_BAND_RD: begin
                state_next = status.band_skip ? ST_RESP : ST_BAND_WR;
            end
            ST_BAND_WR: begin
                state_next = status.band_last ? ST_RESP : ST_BAND_RD;
            end
            ST_CLEAR: begin
                if (status.clr_last) state_next = ST_RESP;
            end
            ST_RESP: begin
                if (status.out_free) state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_INIT:    cmd.clr_write = 1'b1;
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ST_FETCH:   cmd.fetch      = 1'b1;
            ST_PIX_WR:  cmd.pix_write  = 1'b1;
            ST_BAND_RD: cmd.band_read  = !status.band_skip;
            ST_BAND_WR: cmd.band_write = 1'b1;
            ST_CLEAR:   cmd.clr_write  = 1'b1;
            ST_RESP:    cmd.out_load   = status.out_free;
        endcase
    end

endmodule

// File: rtl/core/pnf_datapath.sv
// Datapath of the packed nibble frame buffer: item register, byte store, band and clear
// counters, and the output register.
module pnf_datapath
    import pnf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  pnf_in_t     s_data,
    input  pnf_cmd_t    cmd,
    output pnf_status_t status,
    input  logic        m_ready,
    output logic        m_valid,
    output pnf_out_t    m_data
);

    logic [BYTE_W-1:0] mem [STORE_BYTES];

    pnf_in_t           item_reg;
    logic [BCOL_W-1:0] bx_reg;
    logic [GH_W-1:0]   ri_reg;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic [BYTE_W-1:0] rdata_reg;
    logic              m_valid_reg;
    pnf_out_t          m_data_reg;

    logic [ADDR_CALC_W-1:0] pix_calc;
    logic [ADDR_CALC_W-1:0] band_calc;
    logic [BAND_ROW_W-1:0]  band_row;
    logic [ADDR_W-1:0]      ref_addr;
    logic [BCOL_W-1:0]      bx_start;
    logic                   pix_ok;
    logic                   band_ok;
    logic                   ref_ok;
    logic [31:0]            hi_col;
    logic [31:0]            lo_col;
    logic                   hi_in;
    logic                   lo_in;
    logic                   hilite;
    logic [LVL_W-1:0]       band_lvl;
    logic [LVL_W-1:0]       hi_nib;
    logic [LVL_W-1:0]       lo_nib;
    logic [BYTE_W-1:0]      band_byte;
    logic [BYTE_W-1:0]      pix_byte;
    logic                   mem_we;
    logic                   mem_re;
    logic [ADDR_W-1:0]      mem_waddr;
    logic [ADDR_W-1:0]      mem_raddr;
    logic [BYTE_W-1:0]      mem_wdata;
    pnf_out_t               out_next;

    always_comb begin
        pix_calc = (ADDR_CALC_W'(item_reg.y_pos) << ROW_SHIFT)
                 + ADDR_CALC_W'(item_reg.x_pos >> 1);
        pix_ok   = (32'(item_reg.x_pos) < WIDTH) && (32'(item_reg.y_pos) < HEIGHT)
                && (32'(pix_calc) < STORE_BYTES);

        band_row  = BAND_ROW_W'(32'(item_reg.line_index) * GLYPH_HEIGHT)
                  + BAND_ROW_W'(ri_reg);
        band_calc = (ADDR_CALC_W'(band_row) << ROW_SHIFT) + ADDR_CALC_W'(bx_reg);
        band_ok   = (32'(band_row) < HEIGHT) && (32'(band_calc) < STORE_BYTES);
        bx_start  = BCOL_W'(item_reg.x_pos >> 1);

        ref_ok   = 32'(item_reg.byte_index) < STORE_BYTES;
        ref_addr = ADDR_W'(32'(STORE_BYTES - 1) - 32'(item_reg.byte_index));
    end

    // Each byte holds two band pixels; only those at or right of the start column change.
    always_comb begin
        hi_col   = 32'({bx_reg, 1'b0});
        lo_col   = hi_col + 32'd1;
        hi_in    = (hi_col >= 32'(item_reg.x_pos)) && (hi_col < WIDTH);
        lo_in    = (lo_col >= 32'(item_reg.x_pos)) && (lo_col < WIDTH);
        hilite   = item_reg.operation == OP_HILITE_BAND;
        band_lvl = hilite ? item_reg.level : '0;
        hi_nib   = rdata_reg[7:4];
        lo_nib   = rdata_reg[3:0];
        if (hi_in && (!hilite || hi_nib == '0)) hi_nib = band_lvl;
        if (lo_in && (!hilite || lo_nib == '0)) lo_nib = band_lvl;
        band_byte = {hi_nib, lo_nib};

        pix_byte = item_reg.x_pos[0] ? {rdata_reg[7:4], item_reg.level}
                                     : {item_reg.level, rdata_reg[3:0]};
    end

    always_comb begin
        mem_we    = (cmd.pix_write && pix_ok) || (cmd.band_write && band_ok) || cmd.clr_write;
        mem_waddr = clr_addr_reg;
        mem_wdata = '0;
        if (cmd.pix_write) begin
            mem_waddr = ADDR_W'(pix_calc);
            mem_wdata = pix_byte;
        end else if (cmd.band_write) begin
            mem_waddr = ADDR_W'(band_calc);
            mem_wdata = band_byte;
        end

        mem_re    = cmd.fetch || cmd.band_read;
        mem_raddr = ADDR_W'(band_calc);
        if (cmd.fetch) begin
            mem_raddr = (item_reg.operation == OP_REFRESH) ? ref_addr : ADDR_W'(pix_calc);
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        if (mem_re) rdata_reg <= mem[mem_raddr];
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            item_reg <= s_data;
            bx_reg   <= BCOL_W'(s_data.x_pos >> 1);
            ri_reg   <= '0;
        end else if (cmd.band_write) begin
            if (bx_reg == BCOL_LAST) begin
                bx_reg <= bx_start;
                ri_reg <= ri_reg + GH_W'(1);
            end else begin
                bx_reg <= bx_reg + BCOL_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
        end else if (cmd.clr_write) begin
            clr_addr_reg <= (clr_addr_reg == ADDR_LAST) ? '0 : clr_addr_reg + ADDR_W'(1);
        end
    end

    always_comb begin
        out_next = '0;
        if (item_reg.operation == OP_READ_PIXEL && pix_ok) begin
            out_next.pixel_value = item_reg.x_pos[0] ? rdata_reg[3:0] : rdata_reg[7:4];
        end
        if (item_reg.operation == OP_REFRESH && ref_ok) begin
            out_next.raw_byte = rdata_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) m_data_reg <= out_next;
    end

    assign status.op        = item_reg.operation;
    assign status.band_skip = 32'(item_reg.x_pos) >= WIDTH;
    assign status.band_last = (ri_reg == GH_LAST) && (bx_reg == BCOL_LAST);
    assign status.clr_last  = clr_addr_reg == ADDR_LAST;
    assign status.out_free  = !m_valid_reg || m_ready;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// File: rtl/core/packed_nibble_framebuffer.sv
// Top level of the packed 4-bit-per-pixel frame buffer.
// A 128 x 64 frame of 4-bit pixels is held as 4096 bytes, two pixels per byte (even column in
// the high nibble), in one store with a single write port and a single registered read port.
// Every accepted word yields exactly one result word. After reset the store is cleared, byte by
// byte, while s_ready stays low. One word is handled at a time, from the accepting edge until
// the result is loaded: pixel read and refresh read fetch the byte, pixel write fetches it and
// writes back the merged byte, unused codes go straight to the result, clear writes one byte per
// cycle, and a band reads and then writes back each of its bytes in turn, row by row, from the
// start byte column to the right edge. s_ready returns the cycle after the result
// register is loaded; a result waiting in that register holds off only the loading of the next.
module packed_nibble_framebuffer
    import pnf_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  pnf_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output pnf_out_t m_data
);

    pnf_cmd_t    cmd;
    pnf_status_t status;

    pnf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .op_in   (s_data.operation),
        .s_ready (s_ready),
        .cmd     (cmd),
        .status  (status)
    );

    pnf_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .status  (status),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .m_data  (m_data)
    );

endmodule

// File: rtl/core/pnf_checker.sv
// Port-level checker of the frame buffer and its bind to the top level.
`include "packed_nibble_framebuffer_assert.svh"

module pnf_checker
    import pnf_pkg::*;
(
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input logic     m_valid,
    input logic     m_ready,
    input pnf_out_t m_data
);

    `PNF_ASSERT_NXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))
    `PNF_ASSERT_NXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)
    `PNF_ASSERT_IMP(a_result_after_work, aclk, aresetn, $rose(m_valid), $past(!s_ready))
    `PNF_ASSERT_IMP(a_one_field, aclk, aresetn, m_valid && (m_data.pixel_value != 4'd0), m_data.raw_byte == 8'd0)

endmodule

bind packed_nibble_framebuffer pnf_checker u_pnf_checker (.*);

// File: verif/tb_packed_nibble_framebuffer.sv
// Self-checking testbench for the packed 4-bit-per-pixel frame buffer.
`timescale 1ns / 1ps

module tb_packed_nibble_framebuffer;
    import pnf_pkg::*;

    // Codes that the block treats as no-ops.
    localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int HOLD_STRETCH  = 400;
    localparam int SETTLE_CYCLES = 20;

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    pnf_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    pnf_out_t m_data;

    packed_nibble_framebuffer dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    logic [7:0]  shadow_frame [STORE_BYTES];
    pnf_out_t    pending_results [$];
    pnf_out_t    want_word;
    int          send_idle_pct   = 0;
    int          stall_pct       = 0;
    int          hot_x           = 0;
    int          hot_y           = 0;
    int          op_seen [8]     = '{default: 0};
    int          mismatches      = 0;
    int          results_checked = 0;
    int unsigned cycle_count     = 0;
    logic        hold_go         = 1'b0;
    int          hold_left       = 0;

    // ---------------------------------------------------------------- predictor

    function automatic void wipe_frame();
        foreach (shadow_frame[i]) shadow_frame[i] = 8'h00;
    endfunction

    function automatic bit pixel_slot(input int col, input int row, output int addr);
        if (col >= WIDTH || row >= HEIGHT) return 1'b0;
        addr = (row << ROW_SHIFT) + (col >> 1);
        return addr < STORE_BYTES;
    endfunction

    function automatic void put_pixel(input int col, input int row, input logic [3:0] lvl);
        int addr;
        if (!pixel_slot(col, row, addr)) return;
        if (col[0]) shadow_frame[addr][3:0] = lvl;
        else shadow_frame[addr][7:4] = lvl;
    endfunction

    function automatic logic [3:0] get_pixel(input int col, input int row);
        int addr;
        if (!pixel_slot(col, row, addr)) return 4'h0;
        return col[0] ? shadow_frame[addr][3:0] : shadow_frame[addr][7:4];
    endfunction

    // A highlight only fills pixels that are still dark.
    function automatic void paint_band(input int x0, input int band_line,
                                       input logic [3:0] lvl, input bit only_dark);
        int row0;
        row0 = band_line * GLYPH_HEIGHT;
        for (int c = x0; c < WIDTH; c++) begin
            for (int r = row0; r < row0 + GLYPH_HEIGHT; r++) begin
                if (!(only_dark && get_pixel(c, r) != 4'h0)) put_pixel(c, r, lvl);
            end
        end
    endfunction

    function automatic pnf_out_t frame_op_result(input pnf_in_t w);
        pnf_out_t res;
        res = '0;
        case (w.operation)
            OP_WRITE_PIXEL: put_pixel(w.x_pos, w.y_pos, w.level);
            OP_READ_PIXEL:  res.pixel_value = get_pixel(w.x_pos, w.y_pos);
            OP_BLANK_BAND:  paint_band(w.x_pos, w.line_index, 4'h0, 1'b0);
            OP_HILITE_BAND: paint_band(w.x_pos, w.line_index, w.level, 1'b1);
            OP_CLEAR:       wipe_frame();
            OP_REFRESH: begin
                if (int'(w.byte_index) < STORE_BYTES)
                    res.raw_byte = shadow_frame[STORE_BYTES - 1 - int'(w.byte_index)];
            end
            default: ;
        endcase
        return res;
    endfunction

    // ---------------------------------------------------------------- stimulus helpers

    function automatic void set_idle(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        stall_pct     = recv_pct;
    endfunction

    function automatic void retarget_hot();
        hot_x = $urandom_range(WIDTH - 8);
        hot_y = $urandom_range(HEIGHT - 8);
    endfunction

    function automatic pnf_in_t make_word(input logic [OP_W-1:0] op, input int x, input int y,
                                          input int band_line, input int lvl, input int bidx);
        pnf_in_t w;
        w.operation  = op;
        w.x_pos      = X_W'(x);
        w.y_pos      = Y_W'(y);
        w.line_index = LINE_W'(band_line);
        w.level      = LVL_W'(lvl);
        w.byte_index = BIDX_W'(bidx);
        return w;
    endfunction

    // Most words land in a small window so that writes, reads and bands overlap.
    function automatic pnf_in_t random_word(input logic [OP_W-1:0] op);
        pnf_in_t w;
        int px, py;
        w.operation  = op;
        w.x_pos      = X_W'($urandom_range(WIDTH - 1));
        w.y_pos      = Y_W'($urandom_range(HEIGHT - 1));
        w.line_index = LINE_W'($urandom_range(7));
        w.level      = LVL_W'($urandom_range(15));
        w.byte_index = BIDX_W'($urandom_range(STORE_BYTES - 1));
        if ($urandom_range(99) < 70) begin
            px = hot_x + $urandom_range(7);
            py = hot_y + $urandom_range(7);
            w.x_pos      = X_W'(px);
            w.y_pos      = Y_W'(py);
            w.line_index = LINE_W'(py / GLYPH_HEIGHT);
            w.byte_index = BIDX_W'(STORE_BYTES - 1 - ((py << ROW_SHIFT) + (px >> 1)));
        end
        return w;
    endfunction

    function automatic logic [OP_W-1:0] pick_op();
        int r;
        r = $urandom_range(999);
        if (r < 4)   return OP_CLEAR;
        if (r < 350) return OP_WRITE_PIXEL;
        if (r < 650) return OP_READ_PIXEL;
        if (r < 800) return OP_REFRESH;
        if (r < 850) return OP_BLANK_BAND;
        if (r < 900) return OP_HILITE_BAND;
        if (r < 950) return OP_SPARE_LO;
        return OP_SPARE_HI;
    endfunction

    task automatic send_word(input pnf_in_t w);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(frame_op_result(w));
        op_seen[w.operation]++;
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_directed();
        set_idle(0, 0);
        send_word(make_word(OP_WRITE_PIXEL, 0, 0, 0, 15, 0));
        send_word(make_word(OP_WRITE_PIXEL, 1, 0, 0, 10, 0));
        send_word(make_word(OP_WRITE_PIXEL, WIDTH - 1, HEIGHT - 1, 0, 1, 0));
        send_word(make_word(OP_WRITE_PIXEL, WIDTH - 2, HEIGHT - 1, 0, 0, 0));
        send_word(make_word(OP_READ_PIXEL, 0, 0, 0, 0, 0));
        send_word(make_word(OP_READ_PIXEL, 1, 0, 0, 0, 0));
        send_word(make_word(OP_READ_PIXEL, WIDTH - 1, HEIGHT - 1, 0, 0, 0));
        send_word(make_word(OP_REFRESH, 0, 0, 0, 0, 0));
        send_word(make_word(OP_REFRESH, 0, 0, 0, 0, STORE_BYTES - 1));
        // The highlight must leave the two lit pixels of row zero alone.
        send_word(make_word(OP_HILITE_BAND, 0, 0, 0, 5, 0));
        send_word(make_word(OP_READ_PIXEL, 2, 0, 0, 0, 0));
        send_word(make_word(OP_READ_PIXEL, 1, 0, 0, 0, 0));
        send_word(make_word(OP_HILITE_BAND, WIDTH - 2, 0, 7, 0, 0));
        send_word(make_word(OP_READ_PIXEL, WIDTH - 2, HEIGHT - 1, 0, 0, 0));
        send_word(make_word(OP_BLANK_BAND, WIDTH - 1, 0, 7, 15, 0));
        send_word(make_word(OP_READ_PIXEL, WIDTH - 1, HEIGHT - 1, 0, 0, 0));
        send_word(make_word(OP_REFRESH, 0, 0, 0, 0, 0));
        send_word(make_word(OP_SPARE_LO, WIDTH - 1, HEIGHT - 1, 7, 15, STORE_BYTES - 1));
        send_word(make_word(OP_SPARE_HI, 0, 0, 0, 0, 0));
        send_word(make_word(OP_BLANK_BAND, 0, 0, 0, 0, 0));
        send_word(make_word(OP_CLEAR, 0, 0, 0, 0, 0));
        send_word(make_word(OP_READ_PIXEL, 0, 0, 0, 0, 0));
        send_word(make_word(OP_REFRESH, 0, 0, 0, 0, STORE_BYTES - 1));
    endtask

    task automatic test_pixel_access(input int count);
        int r;
        set_idle(83, 0);
        for (int i = 0; i < count; i++) begin
            if (i % 40 == 0) retarget_hot();
            r = $urandom_range(99);
            if (r < 45)      send_word(random_word(OP_WRITE_PIXEL));
            else if (r < 80) send_word(random_word(OP_READ_PIXEL));
            else             send_word(random_word(OP_REFRESH));
        end
    endtask

    // Light a few pixels, sweep a band across them, then look at the result.
    task automatic test_band_ops(input int rounds);
        set_idle(0, 83);
        repeat (rounds) begin
            retarget_hot();
            repeat (6) send_word(random_word(OP_WRITE_PIXEL));
            send_word(random_word($urandom_range(1) ? OP_BLANK_BAND : OP_HILITE_BAND));
            repeat (5) send_word(random_word(OP_READ_PIXEL));
            repeat (2) send_word(random_word(OP_REFRESH));
        end
    endtask

    task automatic test_clear(input int rounds);
        set_idle(17, 17);
        repeat (rounds) begin
            retarget_hot();
            repeat (4) send_word(random_word(OP_WRITE_PIXEL));
            send_word(random_word(OP_CLEAR));
            repeat (2) send_word(random_word(OP_READ_PIXEL));
            repeat (2) send_word(random_word(OP_REFRESH));
        end
    endtask

    // The receiver stops for a long stretch while words keep coming.
    task automatic test_backpressure(input int count);
        int r;
        set_idle(0, 0);
        retarget_hot();
        s_valid <= 1'b0;
        hold_go <= 1'b1;
        @(posedge aclk);
        hold_go <= 1'b0;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(99);
            if (r < 50)      send_word(random_word(OP_WRITE_PIXEL));
            else if (r < 80) send_word(random_word(OP_READ_PIXEL));
            else             send_word(random_word(OP_REFRESH));
        end
    endtask

    task automatic test_mixed_traffic(input int per_phase);
        int send_pct [4] = '{0, 83, 0, 17};
        int recv_pct [4] = '{0, 0, 83, 17};
        for (int p = 0; p < 4; p++) begin
            set_idle(send_pct[p], recv_pct[p]);
            for (int i = 0; i < per_phase; i++) begin
                if (i % 50 == 0) retarget_hot();
                send_word(random_word(pick_op()));
            end
        end
    endtask

    // ---------------------------------------------------------------- result side

    always @(posedge aclk) begin
        if (hold_go) hold_left <= HOLD_STRETCH;
        else if (hold_left != 0) hold_left <= hold_left - 1;
    end

    always @(posedge aclk) begin
        m_ready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                $display("%0t: result word with nothing pending: pixel_value %0h raw_byte %0h",
                         $time, m_data.pixel_value, m_data.raw_byte);
            end else begin
                want_word = pending_results.pop_front();
                results_checked++;
                if (m_data.pixel_value !== want_word.pixel_value) begin
                    mismatches++;
                    $display("%0t: pixel_value mismatch: expected %0h, actual %0h",
                             $time, want_word.pixel_value, m_data.pixel_value);
                end
                if (m_data.raw_byte !== want_word.raw_byte) begin
                    mismatches++;
                    $display("%0t: raw_byte mismatch: expected %0h, actual %0h",
                             $time, want_word.raw_byte, m_data.raw_byte);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: run stopped after %0d cycles with %0d results outstanding",
                     $time, CYCLE_LIMIT, pending_results.size());
            $display("tb: failure");
            $finish;
        end
    end

    // ---------------------------------------------------------------- sequence

    initial begin
        wipe_frame();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_pixel_access(300);
        test_band_ops(12);
        test_clear(3);
        test_backpressure(30);
        test_mixed_traffic(200);

        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Sent %0d pixel writes, %0d pixel reads, %0d refresh reads, %0d band blanks,",
                 op_seen[OP_WRITE_PIXEL], op_seen[OP_READ_PIXEL], op_seen[OP_REFRESH],
                 op_seen[OP_BLANK_BAND]);
        $display("%0d band highlights, %0d clears, %0d unused codes; %0d results checked.",
                 op_seen[OP_HILITE_BAND], op_seen[OP_CLEAR],
                 op_seen[OP_SPARE_LO] + op_seen[OP_SPARE_HI], results_checked);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
